@@ hdl/rgb_to_hsl_core_assert.svh @@
// ----------------------------------------------------------------------------
// rgb_to_hsl_core_assert.svh
// assertion macros used by the color conversion rtl
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSL_CORE_ASSERT_SVH
`define RGB_TO_HSL_CORE_ASSERT_SVH

// cause is followed by effect a fixed number of cycles later
`define RTH_ASSERT_AFTER(label, clk, rst, cause, n, effect) \
   label: assert property (@(posedge clk) disable iff (rst) (cause) |-> ##(n) (effect)) \
      else $error("rth: expected effect did not follow its cause");

// effect only happens when cause was seen a fixed number of cycles before
`define RTH_ASSERT_SINCE(label, clk, rst, effect, n, cause) \
   label: assert property (@(posedge clk) disable iff (rst) (effect) |-> $past((cause), n)) \
      else $error("rth: effect seen without its cause");

`endif

@@ hdl/rth_pkg.sv @@
// ----------------------------------------------------------------------------
// rth_pkg
// constants and types of the rgb to hsl converter
// ----------------------------------------------------------------------------
package rth_pkg;

   // default fraction width of a color channel
   localparam int FRACTION_BITS_DEF = 16;

   // width of every payload field on the ports
   localparam int FIELD_W = 16;

   // channel holding the maximum, ties resolved red, green, blue
   typedef enum logic [1:0] {
      SEL_RED,
      SEL_GREEN,
      SEL_BLUE
   } max_sel_type;

endpackage

@@ hdl/rgb_to_hsl_core.sv @@
// ----------------------------------------------------------------------------
// rgb_to_hsl_core
// pipelined rgba to hsla conversion, one pixel per clock
// ----------------------------------------------------------------------------
//
//  channel   ports                                  handshake
//  -------   -------------------------------------  -------------------------
//  request   req_red/green/blue/opacity             start, busy
//  response  rsp_hue/saturation/lightness/opacity_out  rsp_valid strobe
//
//  a beat is taken every cycle that start is high and busy is low
//  a request reaches the response strobe through three front stages
//  (min/max, spread/sum, numerators), one restoring divider stage per
//  quotient bit for hue and saturation, and one output stage
//  busy follows reset only; the pipeline never stalls, responses are strobed
//  reset (synchronous) clears the valid bits of every stage
//
`include "rgb_to_hsl_core_assert.svh"

module rgb_to_hsl_core #(
   parameter int FRACTION_BITS = rth_pkg::FRACTION_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [rth_pkg::FIELD_W-1:0] req_red,
   input  logic [rth_pkg::FIELD_W-1:0] req_green,
   input  logic [rth_pkg::FIELD_W-1:0] req_blue,
   input  logic [rth_pkg::FIELD_W-1:0] req_opacity,
   output logic                        rsp_valid,
   output logic [rth_pkg::FIELD_W-1:0] rsp_hue,
   output logic [rth_pkg::FIELD_W-1:0] rsp_saturation,
   output logic [rth_pkg::FIELD_W-1:0] rsp_lightness,
   output logic [rth_pkg::FIELD_W-1:0] rsp_opacity_out
);
   import rth_pkg::*;

   localparam int FB      = FRACTION_BITS;
   localparam int XW      = (FB > FIELD_W) ? FB : FIELD_W;
   localparam int NW      = FB + 3;   // hue numerator and divisor, below 6 * 2^FB
   localparam int LATENCY = FB + 4;

   localparam logic [FB:0] ONE_W   = {1'b0, {FB{1'b1}}};
   localparam logic [FB:0] TWO_ONE = {{FB{1'b1}}, 1'b0};

   logic accept;

   // ------------------------------------------------------------------
   // handshake
   // ------------------------------------------------------------------
   assign busy   = reset;
   assign accept = start && !busy;

   // ------------------------------------------------------------------
   // stage a: mask channels, find max, min and the hue channel difference
   // ------------------------------------------------------------------
   logic [XW-1:0]       r_x, g_x, b_x;
   logic [FB-1:0]       r_m, g_m, b_m;
   logic [FB-1:0]       a_mx_in, a_mn_in;
   max_sel_type         a_sel_in;
   logic [NW-1:0]       a_diff_in;
   logic                a_neg_in;

   logic                a_vld_ff;
   logic [FB-1:0]       a_mx_ff, a_mn_ff;
   max_sel_type         a_sel_ff;
   logic [NW-1:0]       a_diff_ff;
   logic                a_neg_ff;
   logic [FIELD_W-1:0]  a_alpha_ff;

   always_comb begin
      r_x = XW'(req_red);
      g_x = XW'(req_green);
      b_x = XW'(req_blue);
      r_m = r_x[FB-1:0];
      g_m = g_x[FB-1:0];
      b_m = b_x[FB-1:0];

      priority if (r_m >= g_m && r_m >= b_m) begin
         a_sel_in = SEL_RED;
         a_mx_in  = r_m;
      end else if (g_m >= b_m) begin
         a_sel_in = SEL_GREEN;
         a_mx_in  = g_m;
      end else begin
         a_sel_in = SEL_BLUE;
         a_mx_in  = b_m;
      end

      a_mn_in = r_m;
      if (g_m < a_mn_in) a_mn_in = g_m;
      if (b_m < a_mn_in) a_mn_in = b_m;

      a_neg_in = 1'b0;
      unique case (a_sel_in)
         SEL_RED: begin
            a_diff_in = NW'(g_m) - NW'(b_m);
            a_neg_in  = (g_m < b_m);
         end
         SEL_GREEN: a_diff_in = NW'(b_m) - NW'(r_m);
         SEL_BLUE:  a_diff_in = NW'(r_m) - NW'(g_m);
         default:   a_diff_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= accept;
      end
      a_mx_ff    <= a_mx_in;
      a_mn_ff    <= a_mn_in;
      a_sel_ff   <= a_sel_in;
      a_diff_ff  <= a_diff_in;
      a_neg_ff   <= a_neg_in;
      a_alpha_ff <= req_opacity;
   end

   // ------------------------------------------------------------------
   // stage b: spread and sum
   // ------------------------------------------------------------------
   logic                b_vld_ff;
   logic [FB-1:0]       b_d_ff;
   logic [FB:0]         b_sum_ff;
   max_sel_type         b_sel_ff;
   logic [NW-1:0]       b_diff_ff;
   logic                b_neg_ff;
   logic [FIELD_W-1:0]  b_alpha_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else begin
         b_vld_ff <= a_vld_ff;
      end
      b_d_ff     <= a_mx_ff - a_mn_ff;
      b_sum_ff   <= (FB+1)'(a_mx_ff) + (FB+1)'(a_mn_ff);
      b_sel_ff   <= a_sel_ff;
      b_diff_ff  <= a_diff_ff;
      b_neg_ff   <= a_neg_ff;
      b_alpha_ff <= a_alpha_ff;
   end

   // ------------------------------------------------------------------
   // stage c: divider operands and special-case flags
   // ------------------------------------------------------------------
   logic [NW-1:0]       c_d_w;
   logic [NW-1:0]       c_d6;
   logic [NW-1:0]       c_num;
   logic [FB-1:0]       c_sden;
   logic [2*FB-1:0]     c_prod;
   logic                c_hz, c_sz;

   always_comb begin
      c_d_w = NW'(b_d_ff);
      c_d6  = (c_d_w << 2) + (c_d_w << 1);
      unique case (b_sel_ff)
         SEL_RED:   c_num = b_neg_ff ? (c_d6 + b_diff_ff) : b_diff_ff;
         SEL_GREEN: c_num = (c_d_w << 1) + b_diff_ff;
         SEL_BLUE:  c_num = (c_d_w << 2) + b_diff_ff;
         default:   c_num = '0;
      endcase

      // lower formula up to one half, mirrored above it
      if (b_sum_ff <= ONE_W) begin
         c_sden = b_sum_ff[FB-1:0];
      end else begin
         c_sden = FB'(TWO_ONE - b_sum_ff);
      end

      // spread times full scale, as d * 2^FB - d
      c_prod = {b_d_ff, {FB{1'b0}}} - (2*FB)'(b_d_ff);

      c_hz = (b_d_ff == '0);
      c_sz = (b_sum_ff == '0) || (b_sum_ff >= TWO_ONE);
   end

   // ------------------------------------------------------------------
   // restoring divider pipeline, entry 0 loaded by stage c
   // ------------------------------------------------------------------
   logic                vld_ff   [0:FB];
   logic [NW-1:0]       hden_ff  [0:FB];
   logic [NW-1:0]       hrem_ff  [0:FB];
   logic [FB-1:0]       hq_ff    [0:FB];
   logic [FB-1:0]       sden_ff  [0:FB];
   logic [FB-1:0]       srem_ff  [0:FB];
   logic [FB-1:0]       slow_ff  [0:FB];
   logic [FB-1:0]       sq_ff    [0:FB];
   logic                hz_ff    [0:FB];
   logic                sz_ff    [0:FB];
   logic [FB-1:0]       light_ff [0:FB];
   logic [FIELD_W-1:0]  alpha_ff [0:FB];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= b_vld_ff;
      end
      hden_ff[0]  <= c_d6;
      hrem_ff[0]  <= c_num;
      hq_ff[0]    <= '0;
      sden_ff[0]  <= c_sden;
      srem_ff[0]  <= c_prod[2*FB-1:FB];
      slow_ff[0]  <= c_prod[FB-1:0];
      sq_ff[0]    <= '0;
      hz_ff[0]    <= c_hz;
      sz_ff[0]    <= c_sz;
      light_ff[0] <= b_sum_ff[FB:1];
      alpha_ff[0] <= b_alpha_ff;
   end

   for (genvar k = 0; k < FB; k++) begin : g_div
      logic [NW:0]   hsh;
      logic [FB:0]   ssh;
      logic [NW-1:0] hrem_in;
      logic [FB-1:0] srem_in;
      logic          hbit, sbit;

      // one quotient bit of each division per stage
      always_comb begin
         hsh  = {hrem_ff[k], 1'b0};
         ssh  = {srem_ff[k], slow_ff[k][FB-1]};
         hbit = (hsh >= (NW+1)'(hden_ff[k]));
         sbit = (ssh >= (FB+1)'(sden_ff[k]));
         hrem_in = hbit ? NW'(hsh - (NW+1)'(hden_ff[k])) : NW'(hsh);
         srem_in = sbit ? FB'(ssh - (FB+1)'(sden_ff[k])) : FB'(ssh);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else begin
            vld_ff[k+1] <= vld_ff[k];
         end
         hden_ff[k+1]  <= hden_ff[k];
         hrem_ff[k+1]  <= hrem_in;
         hq_ff[k+1]    <= {hq_ff[k][FB-2:0], hbit};
         sden_ff[k+1]  <= sden_ff[k];
         srem_ff[k+1]  <= srem_in;
         slow_ff[k+1]  <= {slow_ff[k][FB-2:0], 1'b0};
         sq_ff[k+1]    <= {sq_ff[k][FB-2:0], sbit};
         hz_ff[k+1]    <= hz_ff[k];
         sz_ff[k+1]    <= sz_ff[k];
         light_ff[k+1] <= light_ff[k];
         alpha_ff[k+1] <= alpha_ff[k];
      end
   end

   // ------------------------------------------------------------------
   // output stage: apply grey and black/white cases, fit to field width
   // ------------------------------------------------------------------
   logic [XW-1:0]       o_hue_x, o_sat_x, o_light_x;
   logic                o_vld_ff;
   logic [FIELD_W-1:0]  o_hue_ff, o_sat_ff, o_light_ff, o_alpha_ff;

   always_comb begin
      o_hue_x   = hz_ff[FB] ? '0 : XW'(hq_ff[FB]);
      o_sat_x   = sz_ff[FB] ? '0 : XW'(sq_ff[FB]);
      o_light_x = XW'(light_ff[FB]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_vld_ff <= 1'b0;
      end else begin
         o_vld_ff <= vld_ff[FB];
      end
      o_hue_ff   <= o_hue_x[FIELD_W-1:0];
      o_sat_ff   <= o_sat_x[FIELD_W-1:0];
      o_light_ff <= o_light_x[FIELD_W-1:0];
      o_alpha_ff <= alpha_ff[FB];
   end

   assign rsp_valid       = o_vld_ff;
   assign rsp_hue         = o_hue_ff;
   assign rsp_saturation  = o_sat_ff;
   assign rsp_lightness   = o_light_ff;
   assign rsp_opacity_out = o_alpha_ff;

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   `RTH_ASSERT_AFTER(a_beat_reaches_output, clock, reset, accept, LATENCY, rsp_valid)
   `RTH_ASSERT_SINCE(a_output_has_source, clock, reset, rsp_valid, LATENCY, accept)

endmodule
